// File: rtl/stsg_pkg.sv
// Shared types, constants and helper functions for the trapezoid step generator.
// Used by every module under rtl/; it depends on nothing else.
package stsg_pkg;

   // Step counter and interval widths
   localparam int STEP_BITS          = 18;
   localparam int INTERVAL_FRAC_BITS = 8;
   localparam int IV_W               = 24;
   localparam int RAMP_W             = 18;
   localparam int CNT_W              = 16;
   localparam int CMP_W              = (STEP_BITS > RAMP_W) ? STEP_BITS : RAMP_W;

   // Serial divider: dividend is 2c, divisor is 4n+1
   localparam int DVD_W      = IV_W + 1;
   localparam int DVS_W      = STEP_BITS + 2;
   localparam int DIV_CNT_W  = $clog2(DVD_W + 1);

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_INTERVAL   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CRUISE_INTERVAL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_STEPS       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_INVERT       = 2'd3;

   localparam logic [CSR_DATA_W-1:0] FIRST_INTERVAL_RST  = 24'd4467200;
   localparam logic [CSR_DATA_W-1:0] CRUISE_INTERVAL_RST = 24'd102400;
   localparam logic [RAMP_W-1:0]     RAMP_STEPS_RST      = 18'd1038;

   // Request function codes
   localparam int FUNC_W = 2;
   localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_MOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_ZERO = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      PH_UP,
      PH_DOWN,
      PH_CRUISE
   } phase_type;

   typedef struct packed {
      logic [IV_W-1:0]   first_interval;
      logic [IV_W-1:0]   cruise_interval;
      logic [RAMP_W-1:0] ramp_steps;
      logic              dir_invert;
   } csr_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic            done;
      logic [IV_W-1:0] quotient;
   } div_rsp_type;

   // Whole microseconds of an interval, saturated to the countdown width
   function automatic logic [CNT_W-1:0] countdown_of(input logic [IV_W-1:0] c);
      logic [IV_W-1:0] whole;
      whole = c >> INTERVAL_FRAC_BITS;
      if (whole > IV_W'({CNT_W{1'b1}})) begin
         return {CNT_W{1'b1}};
      end
      return whole[CNT_W-1:0];
   endfunction

endpackage

// File: rtl/stsg_serial_div.sv
// Bit-serial restoring divider for the ramp interval update, one quotient bit a cycle.
// Depends on stsg_pkg for widths and the request/response structs.
module stsg_serial_div (
   input  logic                 clock,
   input  logic                 reset,
   input  stsg_pkg::div_req_type div_req,
   output stsg_pkg::div_rsp_type div_rsp
);
   import stsg_pkg::*;

   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [DVD_W-1:0]     quo_ff, quo_in;
   logic [DVS_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [DVS_W:0] trial;
   logic [DVS_W:0] diff;
   logic           fits;

   // One restoring step: shift in the next dividend bit and try the subtract
   always_comb begin
      trial = {rem_ff, quo_ff[DVD_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = trial >= {1'b0, dvs_ff};
   end

   // Next values
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         cnt_in  = DIV_CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath shift registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   // Quotient is below 2^IV_W since the divisor is at least five
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff[IV_W-1:0];

endmodule

// File: rtl/stsg_ctrl.sv
// Move sequencer: item capture, ramp bookkeeping, step timing and result register.
// Depends on stsg_pkg; drives the serial divider through div_req/div_rsp.
module stsg_ctrl (
   input  logic                                   clock,
   input  logic                                   reset,
   input  stsg_pkg::csr_type                      csr,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [stsg_pkg::FUNC_W-1:0]            req_func,
   input  logic signed [stsg_pkg::STEP_BITS-1:0]  req_target_steps,
   input  logic                                   req_use_endstop,
   input  logic                                   req_endstop_level,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_step_pulse,
   output logic                                   rsp_direction,
   output logic                                   rsp_busy_res,
   output logic                                   rsp_endstop_hit,
   output logic signed [stsg_pkg::STEP_BITS-1:0]  rsp_position,
   output stsg_pkg::div_req_type                  div_req,
   input  stsg_pkg::div_rsp_type                  div_rsp
);
   import stsg_pkg::*;

   state_type state_ff, state_in;

   // Captured item
   logic [FUNC_W-1:0]      func_ff, func_in;
   logic                   use_es_ff, use_es_in;
   logic                   level_ff, level_in;
   logic signed [STEP_BITS:0] delta_ff, delta_in;
   phase_type              phase_ff, phase_in;

   // Move state
   logic [STEP_BITS-1:0] position_ff, position_in;
   logic [STEP_BITS-1:0] total_ff, total_in;
   logic [STEP_BITS-1:0] done_ff, done_in;
   logic [STEP_BITS-1:0] up_end_ff, up_end_in;
   logic [STEP_BITS-1:0] down_start_ff, down_start_in;
   logic [IV_W-1:0]      interval_ff, interval_in;
   logic [CNT_W-1:0]     countdown_ff, countdown_in;
   logic                 moving_ff, moving_in;
   logic                 dir_ff, dir_in;
   logic                 armed_ff, armed_in;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 pulse_ff, pulse_in;
   logic                 direction_ff, direction_in;
   logic                 busy_ff, busy_in;
   logic                 hit_ff, hit_in;
   logic [STEP_BITS-1:0] pos_out_ff, pos_out_in;

   logic                 accept;
   logic                 slot_free;
   logic                 commit;
   logic                 step_due;
   logic                 needs_div;
   phase_type            phase_sel;
   logic [STEP_BITS-1:0] left;

   // Ramp phase and remaining steps from the current move state
   always_comb begin
      if (done_ff < up_end_ff) begin
         phase_sel = PH_UP;
      end else if (done_ff >= down_start_ff) begin
         phase_sel = PH_DOWN;
      end else begin
         phase_sel = PH_CRUISE;
      end
      left      = (total_ff > done_ff) ? (total_ff - done_ff) : '0;
      step_due  = moving_ff && (countdown_ff < CNT_W'(2));
      needs_div = (req_func == FUNC_TICK) && step_due && (phase_sel != PH_CRUISE);
      accept    = req_valid && req_ready;
      slot_free = !rsp_valid_ff || rsp_ready;
      commit    = (state_ff == ST_DONE) && slot_free;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = needs_div ? ST_DIV : ST_DONE;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // FSM outputs
   always_comb begin
      req_ready        = (state_ff == ST_IDLE);
      div_req.start    = accept && needs_div;
      div_req.dividend = {interval_ff, 1'b0};
      div_req.divisor  = (phase_sel == PH_UP) ? {done_ff, 2'b01} : {left, 2'b01};
   end

   // Item capture; the position difference is formed while the item is taken
   always_comb begin
      func_in   = func_ff;
      use_es_in = use_es_ff;
      level_in  = level_ff;
      delta_in  = delta_ff;
      phase_in  = phase_ff;
      if (accept) begin
         func_in   = req_func;
         use_es_in = req_use_endstop;
         level_in  = req_endstop_level;
         delta_in  = $signed({req_target_steps[STEP_BITS-1], req_target_steps})
                   - $signed({position_ff[STEP_BITS-1], position_ff});
         phase_in  = phase_sel;
      end
   end

   // Item execution, applied at commit
   always_comb begin
      logic              take;
      logic              pulse;
      logic              hit;
      logic [IV_W:0]     up_sum;
      logic [IV_W-1:0]   new_c;
      logic [STEP_BITS:0] mag;
      logic [STEP_BITS-1:0] new_total;
      logic [STEP_BITS-1:0] half;
      logic [CMP_W-1:0]  half_ext;
      logic [CMP_W-1:0]  ramp_ext;
      logic [STEP_BITS-1:0] done_next;

      take      = 1'b0;
      pulse     = 1'b0;
      hit       = 1'b0;
      up_sum    = {1'b0, interval_ff} + {1'b0, div_rsp.quotient};
      new_c     = interval_ff;
      mag       = delta_ff[STEP_BITS] ? (~delta_ff + 1'b1) : delta_ff;
      new_total = mag[STEP_BITS-1:0];
      half      = new_total >> 1;
      half_ext  = CMP_W'(half);
      ramp_ext  = CMP_W'(csr.ramp_steps);

      position_in   = position_ff;
      total_in      = total_ff;
      done_in       = done_ff;
      up_end_in     = up_end_ff;
      down_start_in = down_start_ff;
      interval_in   = interval_ff;
      countdown_in  = countdown_ff;
      moving_in     = moving_ff;
      dir_in        = dir_ff;
      armed_in      = armed_ff;

      case (func_ff)
         FUNC_TICK: begin
            if (moving_ff) begin
               if (countdown_ff > CNT_W'(1)) begin
                  countdown_in = countdown_ff - CNT_W'(1);
               end else begin
                  case (phase_ff)
                     PH_UP:   new_c = interval_ff - div_rsp.quotient;
                     PH_DOWN: new_c = up_sum[IV_W] ? {IV_W{1'b1}} : up_sum[IV_W-1:0];
                     default: new_c = csr.cruise_interval;
                  endcase
                  interval_in  = new_c;
                  countdown_in = countdown_of(new_c);
                  if (armed_ff && !level_ff) begin
                     hit       = 1'b1;
                     moving_in = 1'b0;
                     armed_in  = 1'b0;
                  end else begin
                     pulse = 1'b1;
                     take  = 1'b1;
                  end
               end
            end
         end
         FUNC_MOVE: begin
            if (!moving_ff) begin
               dir_in   = !delta_ff[STEP_BITS];
               total_in = new_total;
               done_in  = '0;
               armed_in = 1'b0;
               if (new_total != '0) begin
                  if (half_ext < ramp_ext) begin
                     up_end_in     = half;
                     down_start_in = half;
                  end else begin
                     up_end_in     = ramp_ext[STEP_BITS-1:0];
                     down_start_in = new_total - ramp_ext[STEP_BITS-1:0];
                  end
                  interval_in  = csr.first_interval;
                  countdown_in = countdown_of(csr.first_interval);
                  if (use_es_ff && !level_ff) begin
                     hit = 1'b1;
                  end else begin
                     moving_in = 1'b1;
                     armed_in  = use_es_ff;
                     pulse     = 1'b1;
                     take      = 1'b1;
                  end
               end
            end
         end
         FUNC_ZERO: begin
            position_in = '0;
         end
         default: begin
         end
      endcase

      // Issue one step; the move ends once every step is taken
      done_next = done_in + 1'b1;
      if (take) begin
         position_in = dir_in ? (position_in + 1'b1) : (position_in - 1'b1);
         done_in     = done_next;
         if (done_next >= total_in) begin
            moving_in = 1'b0;
            armed_in  = 1'b0;
         end
      end

      // Result register
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pulse_in     = pulse_ff;
      direction_in = direction_ff;
      busy_in      = busy_ff;
      hit_in       = hit_ff;
      pos_out_in   = pos_out_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
         pulse_in     = pulse;
         direction_in = dir_in ^ csr.dir_invert;
         busy_in      = moving_in;
         hit_in       = hit;
         pos_out_in   = position_in;
      end
   end

   // Control and move state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         position_ff   <= '0;
         total_ff      <= '0;
         done_ff       <= '0;
         up_end_ff     <= '0;
         down_start_ff <= '0;
         interval_ff   <= '0;
         countdown_ff  <= '0;
         moving_ff     <= 1'b0;
         dir_ff        <= 1'b0;
         armed_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            position_ff   <= position_in;
            total_ff      <= total_in;
            done_ff       <= done_in;
            up_end_ff     <= up_end_in;
            down_start_ff <= down_start_in;
            interval_ff   <= interval_in;
            countdown_ff  <= countdown_in;
            moving_ff     <= moving_in;
            dir_ff        <= dir_in;
            armed_ff      <= armed_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      use_es_ff    <= use_es_in;
      level_ff     <= level_in;
      delta_ff     <= delta_in;
      phase_ff     <= phase_in;
      pulse_ff     <= pulse_in;
      direction_ff <= direction_in;
      busy_ff      <= busy_in;
      hit_ff       <= hit_in;
      pos_out_ff   <= pos_out_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_step_pulse  = pulse_ff;
   assign rsp_direction   = direction_ff;
   assign rsp_busy_res    = busy_ff;
   assign rsp_endstop_hit = hit_ff;
   assign rsp_position    = pos_out_ff;

endmodule

// File: rtl/stepper_trapezoid_step_generator.sv
// Trapezoid step generator: each request (tick, move or zero) gives one response
// carrying the step pulse, direction, busy flag, endstop abort and position.
// Timing: a request is taken in ST_IDLE; its response is registered when ST_DONE
// commits, once the response slot is free. A tick that ends a step interval on the
// acceleration or deceleration ramp first passes through ST_DIV, where the bit-serial
// divider forms 2c/(4n+1) one quotient bit per cycle over a 25-bit dividend.
// One request is in flight at a time; a waiting response holds off the next commit.
// Top level: configuration registers, sequencer (stsg_ctrl) and divider (stsg_serial_div).
module stepper_trapezoid_step_generator (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [stsg_pkg::FUNC_W-1:0]            req_func,
   input  logic signed [stsg_pkg::STEP_BITS-1:0]  req_target_steps,
   input  logic                                   req_use_endstop,
   input  logic                                   req_endstop_level,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_step_pulse,
   output logic                                   rsp_direction,
   output logic                                   rsp_busy_res,
   output logic                                   rsp_endstop_hit,
   output logic signed [stsg_pkg::STEP_BITS-1:0]  rsp_position,
   input  logic                                   csr_wen,
   input  logic [stsg_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [stsg_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import stsg_pkg::*;

   csr_type     csr_ff, csr_in;
   div_req_type div_req;
   div_rsp_type div_rsp;

   // Configuration register writes
   always_comb begin
      csr_in = csr_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_FIRST_INTERVAL:   csr_in.first_interval   = csr_wdata[IV_W-1:0];
            CSR_CRUISE_INTERVAL:  csr_in.cruise_interval  = csr_wdata[IV_W-1:0];
            CSR_RAMP_STEPS:       csr_in.ramp_steps       = csr_wdata[RAMP_W-1:0];
            CSR_DIR_INVERT:       csr_in.dir_invert       = csr_wdata[0];
            default: csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.first_interval   <= FIRST_INTERVAL_RST[IV_W-1:0];
         csr_ff.cruise_interval  <= CRUISE_INTERVAL_RST[IV_W-1:0];
         csr_ff.ramp_steps       <= RAMP_STEPS_RST;
         csr_ff.dir_invert       <= 1'b0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   stsg_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .csr               (csr_ff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_target_steps  (req_target_steps),
      .req_use_endstop   (req_use_endstop),
      .req_endstop_level (req_endstop_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_step_pulse    (rsp_step_pulse),
      .rsp_direction     (rsp_direction),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_endstop_hit   (rsp_endstop_hit),
      .rsp_position      (rsp_position),
      .div_req           (div_req),
      .div_rsp           (div_rsp)
   );

   stsg_serial_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

endmodule

// File: rtl/stsg_checker.sv
// Port-level checks for the trapezoid step generator, bound to the top level.
// Depends on stsg_pkg for the position width.
module stsg_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic                                  rsp_step_pulse,
   input logic                                  rsp_busy_res,
   input logic                                  rsp_endstop_hit,
   input logic signed [stsg_pkg::STEP_BITS-1:0] rsp_position
);
   import stsg_pkg::*;

   // A stalled response keeps its position
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position))
      else $error("response changed while stalled");

   // One request in flight: a request transfer closes the request side
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   // A response never both steps and reports an endstop abort
   a_pulse_or_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_step_pulse && rsp_endstop_hit))
      else $error("step pulse together with endstop abort");

   // An endstop abort leaves the block idle
   a_hit_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_endstop_hit |-> !rsp_busy_res)
      else $error("still busy after endstop abort");

endmodule

bind stepper_trapezoid_step_generator stsg_checker u_checker (.*);
